FILE: rtl/core/double_ended_queue_macros.svh
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, idle in reset
`define DEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, idle in reset
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W      = 3;
  localparam int ITEM_W      = 32;
  localparam int STAT_W      = 2;
  localparam int CNT_W       = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = ITEM_W + STAT_W + CNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_LIST_FWD   = 3'd4,
    FN_LIST_BWD   = 3'd5
  } deq_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } deq_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } deq_state_t;

  // one result word handed from the control to the output register
  typedef struct packed {
    logic               load;
    logic [ITEM_W-1:0]  item;
    deq_status_t        status;
    logic [CNT_W-1:0]   count;
    logic               last;
  } deq_res_t;

endpackage

FILE: rtl/core/double_ended_queue.sv
// push and pop: result word registered in the cycle after the accept, one item per cycle
// listing of n elements: state, ram read and output registers precede the first word,
//   then one word per cycle; the next item is taken after the last word is loaded
// stalls hold the word and pause the rates; the next item is taken in the cycle it drains
// reset (rst_n low, synchronous) empties the deque; store contents are not cleared
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]    in_tdata,   // value
  input  logic [deq_pkg::FUNC_W-1:0]        in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata,  // item_value, status, element_count
  output logic                              out_tlast
);

  localparam int IW = $clog2(DEPTH);

  deq_pkg::deq_res_t      res;
  logic                   out_free;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic                   ram_re;
  logic [IW-1:0]          ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata),
    .in_func   (in_tuser),
    .out_free  (out_free),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  deq_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/core/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/deq_obuf.sv
`timescale 1ns / 1ps

module deq_obuf (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  deq_pkg::deq_res_t                    res,
  output logic                                 out_free,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  logic                              valid_r;
  logic                              valid_nxt;
  logic [deq_pkg::OUT_TDATA_W-1:0]   data_r;
  logic                              last_r;

  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = res.load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      data_r <= {res.count, res.status, res.item};
      last_r <= res.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

FILE: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]    in_value,
  input  logic [deq_pkg::FUNC_W-1:0]        in_func,
  input  logic                              out_free,
  output deq_pkg::deq_res_t                 res,
  output logic                              ram_we,
  output logic [$clog2(DEPTH)-1:0]          ram_waddr,
  output logic [DATA_WIDTH-1:0]             ram_wdata,
  output logic                              ram_re,
  output logic [$clog2(DEPTH)-1:0]          ram_raddr,
  input  logic [DATA_WIDTH-1:0]             ram_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  deq_pkg::deq_state_t state_r, state_nxt;
  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dir_r, dir_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] del_r, del_nxt;
  logic          rdv_r, rdv_nxt;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic [IW-1:0]                 front_dec;
  logic [IW-1:0]                 front_inc;
  logic [CW-1:0]                 list_off;
  logic                          issue;
  logic                          load;
  logic                          list_last;
  logic [deq_pkg::ITEM_W-1:0]    rd_item;

  // ring position of the element at offset off from base
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  generate
    if (DATA_WIDTH >= deq_pkg::ITEM_W) begin : g_wide
      assign rd_item   = ram_rdata[deq_pkg::ITEM_W-1:0];
      assign ram_wdata = {{(DATA_WIDTH-deq_pkg::ITEM_W){in_value[deq_pkg::ITEM_W-1]}}, in_value};
    end else begin : g_narrow
      assign rd_item   = {{(deq_pkg::ITEM_W-DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
      assign ram_wdata = in_value[DATA_WIDTH-1:0];
    end
  endgenerate

  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign list_off  = dir_r ? (count_r - 1'b1 - iss_r) : iss_r;
  assign list_last = (del_r == count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
      front_r <= '0;
      count_r <= '0;
      dir_r   <= 1'b0;
      iss_r   <= '0;
      del_r   <= '0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      dir_r   <= dir_nxt;
      iss_r   <= iss_nxt;
      del_r   <= del_nxt;
      rdv_r   <= rdv_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    dir_nxt    = dir_r;
    iss_nxt    = iss_r;
    del_nxt    = del_r;
    rdv_nxt    = rdv_r;
    in_tready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = front_dec;
    ram_re     = 1'b0;
    ram_raddr  = slot(front_r, list_off);
    issue      = 1'b0;
    load       = 1'b0;
    res.load   = 1'b0;
    res.item   = '0;
    res.status = deq_pkg::ST_OK;
    res.count  = deq_pkg::CNT_W'(count_r);
    res.last   = 1'b1;

    unique case (state_r)
      deq_pkg::S_IDLE: begin
        in_tready = out_free;
        if (accept) begin
          unique case (in_func)
            deq_pkg::FN_PUSH_FRONT, deq_pkg::FN_PUSH_BACK: begin
              res.load = 1'b1;
              if (full) begin
                res.status = deq_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                if (in_func == deq_pkg::FN_PUSH_FRONT) begin
                  ram_waddr = front_dec;
                  front_nxt = front_dec;
                end else begin
                  ram_waddr = slot(front_r, count_r);
                end
                res.count = deq_pkg::CNT_W'(count_nxt);
              end
            end
            deq_pkg::FN_POP_FRONT, deq_pkg::FN_POP_BACK: begin
              res.load = 1'b1;
              if (empty) begin
                res.status = deq_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
                if (in_func == deq_pkg::FN_POP_FRONT) begin
                  front_nxt = front_inc;
                end
                res.count = deq_pkg::CNT_W'(count_nxt);
              end
            end
            deq_pkg::FN_LIST_FWD, deq_pkg::FN_LIST_BWD: begin
              if (empty) begin
                res.load   = 1'b1;
                res.status = deq_pkg::ST_EMPTY;
              end else begin
                state_nxt = deq_pkg::S_LIST;
                dir_nxt   = (in_func == deq_pkg::FN_LIST_BWD);
                iss_nxt   = '0;
                del_nxt   = '0;
                rdv_nxt   = 1'b0;
              end
            end
            default: begin
              // unused codes give no word
            end
          endcase
        end
      end
      deq_pkg::S_LIST: begin
        // one read in flight; the ram holds its data while the output stalls
        load  = rdv_r && out_free;
        issue = (!rdv_r || load) && (iss_r != count_r);
        ram_re = issue;
        if (issue) begin
          iss_nxt = iss_r + 1'b1;
        end
        rdv_nxt = issue ? 1'b1 : (load ? 1'b0 : rdv_r);
        if (load) begin
          res.load = 1'b1;
          res.item = rd_item;
          res.last = list_last;
          del_nxt  = del_r + 1'b1;
          if (list_last) begin
            state_nxt = deq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/deq_checker.sv
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module deq_sva #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast
);

  logic [deq_pkg::ITEM_W-1:0] o_item;
  logic [deq_pkg::STAT_W-1:0] o_stat;
  logic [deq_pkg::CNT_W-1:0]  o_cnt;

  assign o_item = out_tdata[deq_pkg::ITEM_W-1:0];
  assign o_stat = out_tdata[deq_pkg::ITEM_W+deq_pkg::STAT_W-1:deq_pkg::ITEM_W];
  assign o_cnt  = out_tdata[deq_pkg::OUT_TDATA_W-1:deq_pkg::ITEM_W+deq_pkg::STAT_W];

  `DEQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output word changed while stalled")

  `DEQ_ASSERT_NOW(a_cnt_range, out_tvalid, (o_cnt <= DEPTH) || (DEPTH >= 64), "element count above depth")

  `DEQ_ASSERT_NOW(a_mid_list_ok, out_tvalid && !out_tlast, o_stat == deq_pkg::ST_OK, "non-final word with error status")

  `DEQ_ASSERT_NOW(a_err_single, out_tvalid && (o_stat != deq_pkg::ST_OK), out_tlast && (o_item == '0), "error word not single or nonzero item")

  `DEQ_ASSERT_NOW(a_empty_cnt, out_tvalid && (o_stat == deq_pkg::ST_EMPTY), o_cnt == '0, "empty status with nonzero count")

endmodule

bind double_ended_queue deq_sva #(.DEPTH(DEPTH)) u_deq_sva (.*);
